>>> src/sliding_dft_single_bin_defines.svh
// assertion macros shared by the rtl
`ifndef SLIDING_DFT_SINGLE_BIN_DEFINES_SVH
`define SLIDING_DFT_SINGLE_BIN_DEFINES_SVH

// same-cycle implication
`define SDFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sdft_pkg.sv
package sdft_pkg;

   localparam int SDFT_LENGTH = 256;

   localparam int SAMPLE_W = 16;
   localparam int TW_W     = 16;
   localparam int SCALE_W  = 16;
   localparam int OUT_W    = 18;
   localparam int ACC_W    = 40;
   localparam int TW_FRAC  = 15;
   localparam int SC_FRAC  = 16;

   // accumulator split into signed high part and unsigned low part
   localparam int ACC_LO_W = 16;
   localparam int MA_W     = ACC_W - ACC_LO_W + 1;
   localparam int MB_W     = TW_W + 1;
   localparam int PROD_W   = MA_W + MB_W;
   localparam int SUM_W    = PROD_W + ACC_LO_W;
   localparam int Y_W      = SUM_W - SC_FRAC;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TWIDDLE_REAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TWIDDLE_IMAG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SCALE = 2'd2;

   localparam logic signed [TW_W-1:0] TW_RE_RESET = 16'sh7fff;
   localparam logic signed [TW_W-1:0] TW_IM_RESET = 16'sh0000;
   localparam logic [SCALE_W-1:0]     SCALE_RESET = 16'd512;

   typedef enum logic [1:0] {
      A_RE_LO,
      A_RE_HI,
      A_IM_LO,
      A_IM_HI
   } a_sel_type;

   typedef enum logic [1:0] {
      B_TR,
      B_TI,
      B_SCALE
   } b_sel_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      hi;
      logic      neg;
      logic      first;
      logic      dst_im;
   } mul_op_type;

   typedef struct packed {
      logic       accept;
      logic       mul_en;
      mul_op_type mul;
      logic       update;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic busy;
   } dp_status_type;

endpackage

>>> src/sdft_req_if.sv
interface sdft_req_if;
   import sdft_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> src/sdft_rsp_if.sv
interface sdft_rsp_if;
   import sdft_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] out_real;
   logic signed [OUT_W-1:0] out_imag;

   modport source (output valid, output out_real, output out_imag, input ready);
   modport sink (input valid, input out_real, input out_imag, output ready);
endinterface

>>> src/sdft_ram.sv
module sdft_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sdft_ctrl.sv
`include "sliding_dft_single_bin_defines.svh"

module sdft_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sdft_pkg::dp_status_type status,
   output sdft_pkg::dp_cmd_type  cmd
);
   import sdft_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MAC    = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_UPDATE = 7'b0001000,
      ST_SCALE  = 7'b0010000,
      ST_FLUSH  = 7'b0100000,
      ST_RESULT = 7'b1000000
   } state_type;

   localparam logic [2:0] MAC_LAST   = 3'd7;
   localparam logic [2:0] SCALE_LAST = 3'd3;

   state_type  state_ff;
   state_type  state_in;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;

   // twiddle product: real then imag, four partial products each
   function automatic mul_op_type mac_op(input logic [2:0] step);
      mul_op_type op;
      case (step)
         3'd0: op = '{a_sel: A_RE_LO, b_sel: B_TR, hi: 1'b0, neg: 1'b0, first: 1'b1,
                      dst_im: 1'b0};
         3'd1: op = '{a_sel: A_RE_HI, b_sel: B_TR, hi: 1'b1, neg: 1'b0, first: 1'b0,
                      dst_im: 1'b0};
         3'd2: op = '{a_sel: A_IM_LO, b_sel: B_TI, hi: 1'b0, neg: 1'b1, first: 1'b0,
                      dst_im: 1'b0};
         3'd3: op = '{a_sel: A_IM_HI, b_sel: B_TI, hi: 1'b1, neg: 1'b1, first: 1'b0,
                      dst_im: 1'b0};
         3'd4: op = '{a_sel: A_RE_LO, b_sel: B_TI, hi: 1'b0, neg: 1'b0, first: 1'b1,
                      dst_im: 1'b1};
         3'd5: op = '{a_sel: A_RE_HI, b_sel: B_TI, hi: 1'b1, neg: 1'b0, first: 1'b0,
                      dst_im: 1'b1};
         3'd6: op = '{a_sel: A_IM_LO, b_sel: B_TR, hi: 1'b0, neg: 1'b0, first: 1'b0,
                      dst_im: 1'b1};
         default: op = '{a_sel: A_IM_HI, b_sel: B_TR, hi: 1'b1, neg: 1'b0, first: 1'b0,
                         dst_im: 1'b1};
      endcase
      return op;
   endfunction

   // output scaling of the new accumulator
   function automatic mul_op_type scale_op(input logic [1:0] step);
      mul_op_type op;
      case (step)
         2'd0: op = '{a_sel: A_RE_LO, b_sel: B_SCALE, hi: 1'b0, neg: 1'b0, first: 1'b1,
                      dst_im: 1'b0};
         2'd1: op = '{a_sel: A_RE_HI, b_sel: B_SCALE, hi: 1'b1, neg: 1'b0, first: 1'b0,
                      dst_im: 1'b0};
         2'd2: op = '{a_sel: A_IM_LO, b_sel: B_SCALE, hi: 1'b0, neg: 1'b0, first: 1'b1,
                      dst_im: 1'b1};
         default: op = '{a_sel: A_IM_HI, b_sel: B_SCALE, hi: 1'b1, neg: 1'b0, first: 1'b0,
                         dst_im: 1'b1};
      endcase
      return op;
   endfunction

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = 3'd0;
               state_in   = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.mul_en = 1'b1;
            cmd.mul    = mac_op(cnt_ff);
            cnt_in     = cnt_ff + 3'd1;
            if (cnt_ff == MAC_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = 3'd0;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.mul_en = 1'b1;
            cmd.mul    = scale_op(cnt_ff[1:0]);
            cnt_in     = cnt_ff + 3'd1;
            if (cnt_ff == SCALE_LAST) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   `SDFT_ASSERT_NEXT(a_accept_starts_mac, cmd.accept, state_ff == ST_MAC && cnt_ff == 3'd0, "accept did not start mac sequence")
   `SDFT_ASSERT_NEXT(a_mac_ends_drain, state_ff == ST_MAC && cnt_ff == MAC_LAST, state_ff == ST_DRAIN, "mac sequence overran")
   `SDFT_ASSERT_NEXT(a_scale_ends_flush, state_ff == ST_SCALE && cnt_ff == SCALE_LAST, state_ff == ST_FLUSH, "scale sequence overran")
   `SDFT_ASSERT_NOW(a_ready_only_when_quiet, req_ready, !status.busy, "ready while datapath pipeline busy")

endmodule

>>> src/sdft_dp.sv
`include "sliding_dft_single_bin_defines.svh"

module sdft_dp #(
   parameter int LENGTH = sdft_pkg::SDFT_LENGTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sdft_pkg::dp_cmd_type                 cmd,
   output sdft_pkg::dp_status_type              status,
   input  logic signed [sdft_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 csr_we,
   input  logic [sdft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sdft_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sdft_pkg::OUT_W-1:0]    rsp_out_real,
   output logic signed [sdft_pkg::OUT_W-1:0]    rsp_out_imag
);
   import sdft_pkg::*;

   localparam int                IDX_W    = $clog2(LENGTH);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(LENGTH - 1);

   logic signed [TW_W-1:0]     tw_re_ff;
   logic signed [TW_W-1:0]     tw_im_ff;
   logic [SCALE_W-1:0]         scale_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic [IDX_W-1:0]           idx_in;
   logic                       full_ff;
   logic                       full_in;
   logic signed [ACC_W-1:0]    acc_re_ff;
   logic signed [ACC_W-1:0]    acc_im_ff;
   logic signed [ACC_W-1:0]    acc_re_in;
   logic signed [ACC_W-1:0]    acc_im_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   mul_op_type                 pctl_ff;
   logic                       pvalid_ff;
   logic signed [SUM_W-1:0]    sum_re_ff;
   logic signed [SUM_W-1:0]    sum_im_ff;
   logic signed [SUM_W-1:0]    term;
   logic signed [SUM_W-1:0]    base;
   logic signed [SUM_W-1:0]    total;
   logic signed [MA_W-1:0]     a_op;
   logic signed [MB_W-1:0]     b_op;
   logic signed [OUT_W-1:0]    out_re_ff;
   logic signed [OUT_W-1:0]    out_im_ff;
   logic                       rsp_valid_ff;
   logic                       csr_clear;
   logic [IDX_W-1:0]           idx_next;
   logic [SAMPLE_W-1:0]        ram_rdata;
   logic signed [SAMPLE_W-1:0] oldest;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Y_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v[Y_W-1:OUT_W-1] == {(Y_W-OUT_W+1){v[Y_W-1]}}) begin
         r = v[OUT_W-1:0];
      end else if (v[Y_W-1]) begin
         r = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(OUT_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   always_comb begin
      case (csr_index)
         CSR_TWIDDLE_REAL: csr_clear = csr_we;
         CSR_TWIDDLE_IMAG: csr_clear = csr_we;
         CSR_OUTPUT_SCALE: csr_clear = csr_we;
         default:          csr_clear = 1'b0;
      endcase
   end

   // sample store, entries not yet written since clear read as zero
   sdft_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LENGTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (idx_next),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (idx_next),
      .rd_data (ram_rdata)
   );

   assign oldest = full_ff ? $signed(ram_rdata) : '0;

   // multiplier operands
   always_comb begin
      case (cmd.mul.a_sel)
         A_RE_LO: a_op = {{(MA_W-ACC_LO_W){1'b0}}, acc_re_ff[ACC_LO_W-1:0]};
         A_RE_HI: a_op = {acc_re_ff[ACC_W-1], acc_re_ff[ACC_W-1:ACC_LO_W]};
         A_IM_LO: a_op = {{(MA_W-ACC_LO_W){1'b0}}, acc_im_ff[ACC_LO_W-1:0]};
         A_IM_HI: a_op = {acc_im_ff[ACC_W-1], acc_im_ff[ACC_W-1:ACC_LO_W]};
         default: a_op = '0;
      endcase
      case (cmd.mul.b_sel)
         B_TR:    b_op = {tw_re_ff[TW_W-1], tw_re_ff};
         B_TI:    b_op = {tw_im_ff[TW_W-1], tw_im_ff};
         B_SCALE: b_op = {1'b0, scale_ff};
         default: b_op = '0;
      endcase
   end

   assign prod_in = a_op * b_op;

   // accumulate registered partial product
   always_comb begin
      if (pctl_ff.hi) begin
         term = {prod_ff, {ACC_LO_W{1'b0}}};
      end else begin
         term = {{ACC_LO_W{prod_ff[PROD_W-1]}}, prod_ff};
      end
      if (pctl_ff.first) begin
         base = '0;
      end else if (pctl_ff.dst_im) begin
         base = sum_im_ff;
      end else begin
         base = sum_re_ff;
      end
      total = pctl_ff.neg ? base - term : base + term;
   end

   // recurrence update, wraps at accumulator width
   assign acc_re_in = sum_re_ff[ACC_W+TW_FRAC-1:TW_FRAC]
                      + ACC_W'(sample_ff) - ACC_W'(oldest);
   assign acc_im_in = sum_im_ff[ACC_W+TW_FRAC-1:TW_FRAC];
   assign idx_in    = idx_next;
   assign full_in   = full_ff | (idx_next == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_re_ff     <= TW_RE_RESET;
         tw_im_ff     <= TW_IM_RESET;
         scale_ff     <= SCALE_RESET;
         idx_ff       <= LAST_IDX;
         full_ff      <= 1'b0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.mul_en;
         if (csr_clear) begin
            case (csr_index)
               CSR_TWIDDLE_REAL: tw_re_ff <= csr_wdata;
               CSR_TWIDDLE_IMAG: tw_im_ff <= csr_wdata;
               default:          scale_ff <= csr_wdata;
            endcase
            idx_ff    <= LAST_IDX;
            full_ff   <= 1'b0;
            acc_re_ff <= '0;
            acc_im_ff <= '0;
         end else if (cmd.update) begin
            idx_ff    <= idx_in;
            full_ff   <= full_in;
            acc_re_ff <= acc_re_in;
            acc_im_ff <= acc_im_in;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         pctl_ff <= cmd.mul;
      end
      if (pvalid_ff) begin
         if (pctl_ff.dst_im) begin
            sum_im_ff <= total;
         end else begin
            sum_re_ff <= total;
         end
      end
      if (cmd.load_out) begin
         out_re_ff <= sat_out(sum_re_ff[SUM_W-1:SC_FRAC]);
         out_im_ff <= sat_out(sum_im_ff[SUM_W-1:SC_FRAC]);
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.busy     = pvalid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_real    = out_re_ff;
   assign rsp_out_imag    = out_im_ff;

   `SDFT_ASSERT_NOW(a_update_after_drain, cmd.update, !pvalid_ff, "update before product pipeline drained")
   `SDFT_ASSERT_NOW(a_load_after_drain, cmd.load_out, !pvalid_ff, "result loaded before scale drained")
   `SDFT_ASSERT_NEXT(a_csr_clears, csr_clear, acc_re_ff == '0 && acc_im_ff == '0 && idx_ff == LAST_IDX && !full_ff, "config write did not clear state")
   `SDFT_ASSERT_NOW(a_full_on_last, $rose(full_ff), idx_ff == LAST_IDX, "store marked full before last entry written")

endmodule

>>> src/sliding_dft_single_bin.sv
// channel   dir  handshake      payload
// req_chan  in   valid/ready    sample
// rsp_chan  out  valid/ready    out_real, out_imag
// csr       in   csr_we         csr_index, csr_wdata
//
// one sample at a time: the next is accepted only after the previous result is loaded for output
// one shared 25x17 multiplier does 8 partial products per twiddle update and 4 for scaling
// reset and any write to a defined config register clear accumulators and store index, no clearing pass
// a waiting result holds the core in its last state until taken

module sliding_dft_single_bin #(
   parameter int LENGTH = sdft_pkg::SDFT_LENGTH
) (
   input  logic                            clock,
   input  logic                            reset,
   sdft_req_if.sink                        req_chan,
   sdft_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [sdft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sdft_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sdft_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   sdft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdft_dp #(
      .LENGTH (LENGTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_chan.sample),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_out_real (rsp_chan.out_real),
      .rsp_out_imag (rsp_chan.out_imag)
   );

   assign req_chan.ready = req_ready;

endmodule

>>> tb/sv/sliding_dft_single_bin_test.sv
`timescale 1ns / 100ps

module sliding_dft_single_bin_test;
   import sdft_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint BIN_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint BIN_MIN = -(longint'(1) <<< (OUT_W - 1));

   typedef struct {
      logic signed [OUT_W-1:0] out_real;
      logic signed [OUT_W-1:0] out_imag;
   } bin_value_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sdft_req_if req_if ();
   sdft_rsp_if rsp_if ();

   sliding_dft_single_bin u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bin state kept alongside the block
   logic signed [SAMPLE_W-1:0] window_mem [SDFT_LENGTH];
   int                         window_ptr;
   logic signed [ACC_W-1:0]    bin_acc_re;
   logic signed [ACC_W-1:0]    bin_acc_im;
   logic signed [TW_W-1:0]     twiddle_re;
   logic signed [TW_W-1:0]     twiddle_im;
   logic [SCALE_W-1:0]         bin_scale;

   bin_value_type bin_expected [$];
   int            mismatch_count = 0;
   bit            steady = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_window();
      foreach (window_mem[i]) window_mem[i] = '0;
      window_ptr = SDFT_LENGTH - 1;
      bin_acc_re = '0;
      bin_acc_im = '0;
   endfunction

   function automatic logic signed [OUT_W-1:0] scale_bin(input logic signed [ACC_W-1:0] acc);
      longint prod;
      longint y;
      prod = longint'(acc) * longint'({1'b0, bin_scale});
      y = prod >>> SC_FRAC;
      if (y > BIN_MAX) y = BIN_MAX;
      if (y < BIN_MIN) y = BIN_MIN;
      return y[OUT_W-1:0];
   endfunction

   function automatic bin_value_type slide_bin(input logic signed [SAMPLE_W-1:0] s);
      longint pr;
      longint pi;
      longint nr;
      longint ni;
      logic signed [SAMPLE_W-1:0] oldest;
      bin_value_type v;
      window_ptr = (window_ptr == SDFT_LENGTH - 1) ? 0 : window_ptr + 1;
      oldest = window_mem[window_ptr];
      pr = longint'(bin_acc_re) * longint'(twiddle_re)
           - longint'(bin_acc_im) * longint'(twiddle_im);
      pi = longint'(bin_acc_re) * longint'(twiddle_im)
           + longint'(bin_acc_im) * longint'(twiddle_re);
      nr = (pr >>> TW_FRAC) + longint'(s) - longint'(oldest);
      ni = pi >>> TW_FRAC;
      bin_acc_re = nr[ACC_W-1:0];
      bin_acc_im = ni[ACC_W-1:0];
      window_mem[window_ptr] = s;
      v.out_real = scale_bin(bin_acc_re);
      v.out_imag = scale_bin(bin_acc_im);
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (bin_expected.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      repeat (20) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TWIDDLE_REAL: twiddle_re = value;
         CSR_TWIDDLE_IMAG: twiddle_im = value;
         CSR_OUTPUT_SCALE: bin_scale = value;
         default: return;
      endcase
      clear_window();
   endtask

   // entered and left at a falling edge, valid left high
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bin_expected.push_back(slide_bin(s));
      @(negedge clock);
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // result checker
   always @(posedge clock) begin
      bin_value_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (bin_expected.size() == 0) begin
            note_mismatch($sformatf("unexpected result out_real %0d out_imag %0d",
                                    rsp_if.out_real, rsp_if.out_imag));
         end else begin
            want = bin_expected.pop_front();
            if (rsp_if.out_real !== want.out_real || rsp_if.out_imag !== want.out_imag) begin
               note_mismatch($sformatf("out_real exp %0d got %0d, out_imag exp %0d got %0d",
                                       want.out_real, rsp_if.out_real,
                                       want.out_imag, rsp_if.out_imag));
            end
         end
      end
   end

   // result side stalls
   initial begin
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   task automatic test_power_on_defaults();
      logic signed [SAMPLE_W-1:0] pattern [10];
      pattern = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                  16'sh0001, 16'sh5555, 16'shaaaa, 16'sh8000, 16'sh7fff};
      foreach (pattern[i]) send_sample(pattern[i]);
   endtask

   // an unused index must leave the window intact
   task automatic test_unused_register();
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      repeat (3) send_sample(rand_sample());
   endtask

   task automatic test_extreme_settings();
      write_reg(CSR_TWIDDLE_REAL, 16'h8000);
      write_reg(CSR_TWIDDLE_IMAG, 16'h8000);
      write_reg(CSR_OUTPUT_SCALE, 16'hffff);
      for (int i = 0; i < 12; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7fff);
   endtask

   // long run at one setting so the window wraps around
   task automatic test_random_window();
      write_reg(CSR_TWIDDLE_REAL, CSR_DATA_W'($urandom));
      write_reg(CSR_TWIDDLE_IMAG, CSR_DATA_W'($urandom));
      write_reg(CSR_OUTPUT_SCALE, CSR_DATA_W'($urandom));
      steady = 1'b1;
      for (int i = 0; i < 300; i++) begin
         if (i == 60) steady = 1'b0;
         if (i == 150) wait_drained();
         send_sample(rand_sample());
      end
   endtask

   // twiddle gain above one drives the accumulator into wrap
   task automatic test_unstable_twiddle();
      write_reg(CSR_TWIDDLE_REAL, 16'h7fff);
      write_reg(CSR_TWIDDLE_IMAG, 16'h7fff);
      write_reg(CSR_OUTPUT_SCALE, CSR_DATA_W'($urandom));
      repeat (80) send_sample(rand_sample());
   endtask

   task automatic test_scale_range();
      write_reg(CSR_TWIDDLE_REAL, 16'h0000);
      write_reg(CSR_TWIDDLE_IMAG, 16'h8000);
      write_reg(CSR_OUTPUT_SCALE, 16'h0000);
      repeat (20) send_sample(rand_sample());
      write_reg(CSR_OUTPUT_SCALE, CSR_DATA_W'($urandom));
      repeat (50) send_sample(rand_sample());
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      twiddle_re = TW_RE_RESET;
      twiddle_im = TW_IM_RESET;
      bin_scale = SCALE_RESET;
      clear_window();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_power_on_defaults();
      test_unused_register();
      test_extreme_settings();
      test_random_window();
      test_unstable_twiddle();
      test_scale_range();

      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
